FILE: hw/rtl/twin_slot_gap_finder_assert.svh
// assertion macros for the twin slot gap finder
// needs nothing; taken in by files that check their own logic

`ifndef TWIN_SLOT_GAP_FINDER_ASSERT_SVH
`define TWIN_SLOT_GAP_FINDER_ASSERT_SVH

// same-cycle implication, off during reset
`define TSGF_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("tsgf assertion failed");

// next-cycle implication, off during reset
`define TSGF_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("tsgf assertion failed");

`endif

FILE: hw/rtl/tsgf_pkg.sv
// shared constants, prime table and control structs for the twin slot gap finder
// no dependencies

package tsgf_pkg;

   localparam int VALUE_BITS  = 64;
   localparam int RES_BITS    = 9;
   localparam int TABLE_SIZE  = 64;
   localparam int TABLE_BITS  = 6;
   localparam int PRIME_COUNT = 64;
   localparam int GAP_BITS    = 16;
   localparam int DIGIT_BITS  = 4;

   localparam int IDX_BITS = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1;
   localparam int CNT_BITS = $clog2(PRIME_COUNT + 1);

   localparam logic [RES_BITS-1:0] BOUND_RESET = RES_BITS'(311);
   localparam logic [RES_BITS-1:0] SLOT_OFFSET = RES_BITS'(2);
   localparam logic [GAP_BITS-1:0] GAP_LIMIT   = '1;

   localparam logic [RES_BITS-1:0] PRIME_TABLE [TABLE_SIZE] = '{
      9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,
      9'd23,  9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,
      9'd59,  9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,
      9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131,
      9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
      9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
      9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263,
      9'd269, 9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311
   };

   typedef struct packed {
      logic                start;
      logic [RES_BITS-1:0] modulus;
   } tsgf_mod_req_type;

   typedef struct packed {
      logic                done;
      logic [RES_BITS-1:0] residue;
   } tsgf_mod_rsp_type;

endpackage

FILE: hw/rtl/twin_slot_gap_finder.sv
// top level of the twin slot gap finder: sequencer, residue store, result register
// depends on tsgf_pkg, tsgf_ram, tsgf_residue_unit and twin_slot_gap_finder_assert.svh

// An item is taken when start is high and busy is low; busy then stays high until
// the result has been registered. The result is marked on the rsp_ ports by
// rsp_strobe, high for exactly one cycle, and must be captured then: there is no way
// to hold it off. With n table primes at or below prime_bound, an item first fills
// the residue store, each prime taking one pass of the shared four-bits-a-cycle
// remainder unit; the forward walk then does one store read-modify-write per prime
// for each candidate, until it finds a slot or runs to the gap limit. The user must
// write prime_bound through csr_write_enable and csr_write_data only while the
// block is idle; the block itself does not enforce this.

`include "twin_slot_gap_finder_assert.svh"

module twin_slot_gap_finder
   import tsgf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_position,
   output logic                  rsp_strobe,
   output logic                  rsp_is_slot,
   output logic [GAP_BITS-1:0]   rsp_forward_gap,
   output logic                  rsp_gap_saturated,
   input  logic                  csr_write_enable,
   input  logic [RES_BITS-1:0]   csr_write_data
);

   // sequencer states
   localparam logic [2:0] ST_IDLE        = 3'd0;
   localparam logic [2:0] ST_INIT_NEXT   = 3'd1;
   localparam logic [2:0] ST_INIT_WAIT   = 3'd2;
   localparam logic [2:0] ST_SWEEP_START = 3'd3;
   localparam logic [2:0] ST_SWEEP       = 3'd4;
   localparam logic [2:0] ST_DECIDE      = 3'd5;

   localparam logic [VALUE_BITS-1:0] VALUE_MAX  = '1;
   localparam logic [VALUE_BITS-1:0] VALUE_MAX1 = VALUE_MAX - VALUE_BITS'(1);

   // control registers
   logic [2:0]            state_ff, state_in;
   logic [RES_BITS-1:0]   bound_ff, bound_in;
   logic                  pend_ff, pend_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;

   // working registers
   logic [CNT_BITS-1:0]   k_ff, k_in;
   logic [IDX_BITS-1:0]   pend_idx_ff, pend_idx_in;
   logic [VALUE_BITS-1:0] cand_ff, cand_in;
   logic [GAP_BITS-1:0]   dist_ff, dist_in;
   logic                  slot_ok_ff, slot_ok_in;
   logic                  pass_ff, pass_in;
   logic                  wrap_ff, wrap_in;
   logic                  ymax2_ff, ymax2_in;
   logic                  ymax1_ff, ymax1_in;
   logic                  rsp_is_slot_ff, rsp_is_slot_in;
   logic [GAP_BITS-1:0]   rsp_gap_ff, rsp_gap_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   // datapath wires
   logic [IDX_BITS-1:0]   k_idx;
   logic [RES_BITS-1:0]   k_prime;
   logic                  k_used;
   logic [RES_BITS-1:0]   pend_prime;
   logic [RES_BITS-1:0]   rd_inc;
   logic [RES_BITS-1:0]   rd_new;
   logic [VALUE_BITS-1:0] cand_next;
   logic                  x_ymax2;
   logic                  x_ymax1;

   // residue store and remainder unit handshakes
   tsgf_mod_req_type      mod_req;
   tsgf_mod_rsp_type      mod_rsp;
   logic                  ram_wr_en;
   logic [IDX_BITS-1:0]   ram_wr_addr;
   logic [RES_BITS-1:0]   ram_wr_data;
   logic                  ram_rd_en;
   logic [IDX_BITS-1:0]   ram_rd_addr;
   logic [RES_BITS-1:0]   ram_rd_data;

   function automatic logic [RES_BITS-1:0] prime_at(input logic [IDX_BITS-1:0] idx);
      logic [TABLE_BITS-1:0] t;
      t = TABLE_BITS'(idx);
      return PRIME_TABLE[t];
   endfunction

   // r is the candidate's residue mod p; x+2 wraps to zero or one at the very top
   function automatic logic blocked(input logic [RES_BITS-1:0] r,
                                    input logic [RES_BITS-1:0] p,
                                    input logic y_is_zero,
                                    input logic y_is_one);
      return (r == '0) || y_is_zero || (!y_is_one && (r == p - SLOT_OFFSET));
   endfunction

   tsgf_residue_unit u_residue (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .value (cand_ff),
      .rsp   (mod_rsp)
   );

   tsgf_ram #(
      .WIDTH (RES_BITS),
      .DEPTH (PRIME_COUNT)
   ) u_residue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // prime k takes part while it is inside the table and not above the bound
   assign k_idx   = k_ff[IDX_BITS-1:0];
   assign k_prime = prime_at(k_idx);
   assign k_used  = (k_ff < CNT_BITS'(PRIME_COUNT)) && (k_prime <= bound_ff);

   // next candidate residue: step by one modulo the prime, or restart at zero when the position wraps
   assign pend_prime = prime_at(pend_idx_ff);
   assign rd_inc     = ram_rd_data + RES_BITS'(1);
   assign rd_new     = (wrap_ff || (rd_inc == pend_prime)) ? '0 : rd_inc;

   assign cand_next = cand_ff + VALUE_BITS'(1);
   assign x_ymax2   = (cand_ff == VALUE_MAX1);
   assign x_ymax1   = (cand_ff == VALUE_MAX);

   always_comb begin
      state_in       = state_ff;
      bound_in       = bound_ff;
      pend_in        = 1'b0;
      rsp_strobe_in  = 1'b0;
      k_in           = k_ff;
      pend_idx_in    = pend_idx_ff;
      cand_in        = cand_ff;
      dist_in        = dist_ff;
      slot_ok_in     = slot_ok_ff;
      pass_in        = pass_ff;
      wrap_in        = wrap_ff;
      ymax2_in       = ymax2_ff;
      ymax1_in       = ymax1_ff;
      rsp_is_slot_in = rsp_is_slot_ff;
      rsp_gap_in     = rsp_gap_ff;
      rsp_sat_in     = rsp_sat_ff;
      mod_req.start   = 1'b0;
      mod_req.modulus = k_prime;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = k_idx;
      ram_wr_data    = mod_rsp.residue;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = k_idx;

      if (csr_write_enable) begin
         bound_in = csr_write_data;
      end

      // read-modify-write stage of the walk, in the cycle after the read
      if (pend_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = pend_idx_ff;
         ram_wr_data = rd_new;
         if (blocked(rd_new, pend_prime, ymax2_ff, ymax1_ff)) begin
            pass_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cand_in    = req_position;
               k_in       = '0;
               slot_ok_in = 1'b1;
               dist_in    = '0;
               state_in   = ST_INIT_NEXT;
            end
         end
         ST_INIT_NEXT: begin
            // residue of the start position for each prime in use
            if (k_used) begin
               mod_req.start = 1'b1;
               state_in      = ST_INIT_WAIT;
            end else begin
               state_in = ST_SWEEP_START;
            end
         end
         ST_INIT_WAIT: begin
            if (mod_rsp.done) begin
               ram_wr_en = 1'b1;
               if (blocked(mod_rsp.residue, k_prime, x_ymax2, x_ymax1)) begin
                  slot_ok_in = 1'b0;
               end
               k_in     = k_ff + CNT_BITS'(1);
               state_in = ST_INIT_NEXT;
            end
         end
         ST_SWEEP_START: begin
            cand_in  = cand_next;
            dist_in  = dist_ff + GAP_BITS'(1);
            wrap_in  = (cand_next == '0);
            ymax2_in = (cand_next == VALUE_MAX1);
            ymax1_in = (cand_next == VALUE_MAX);
            pass_in  = 1'b1;
            k_in     = '0;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (k_used) begin
               ram_rd_en   = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = k_idx;
               k_in        = k_ff + CNT_BITS'(1);
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (pass_ff) begin
               rsp_strobe_in  = 1'b1;
               rsp_is_slot_in = slot_ok_ff;
               rsp_gap_in     = dist_ff;
               rsp_sat_in     = 1'b0;
               state_in       = ST_IDLE;
            end else if (dist_ff == GAP_LIMIT) begin
               // walk ran out without a slot
               rsp_strobe_in  = 1'b1;
               rsp_is_slot_in = slot_ok_ff;
               rsp_gap_in     = GAP_LIMIT;
               rsp_sat_in     = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               state_in = ST_SWEEP_START;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bound_ff      <= BOUND_RESET;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bound_ff      <= bound_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff           <= k_in;
      pend_idx_ff    <= pend_idx_in;
      cand_ff        <= cand_in;
      dist_ff        <= dist_in;
      slot_ok_ff     <= slot_ok_in;
      pass_ff        <= pass_in;
      wrap_ff        <= wrap_in;
      ymax2_ff       <= ymax2_in;
      ymax1_ff       <= ymax1_in;
      rsp_is_slot_ff <= rsp_is_slot_in;
      rsp_gap_ff     <= rsp_gap_in;
      rsp_sat_ff     <= rsp_sat_in;
   end

   // busy covers the whole item, result register included
   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_is_slot       = rsp_is_slot_ff;
   assign rsp_forward_gap   = rsp_gap_ff;
   assign rsp_gap_saturated = rsp_sat_ff;

   // a result pulse never lasts past one cycle
   `TSGF_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   // the sequencer is back at rest while its result is shown
   `TSGF_ASSERT_IMPLY(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   // a saturated walk always reports the gap limit
   `TSGF_ASSERT_IMPLY(a_sat_limit, clock, reset, rsp_strobe && rsp_gap_saturated,
                      rsp_forward_gap == GAP_LIMIT)
   // an accepted item keeps the block busy
   `TSGF_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

endmodule

FILE: hw/rtl/tsgf_ram.sv
// generic single write, single read ram with registered read data
// no dependencies

module tsgf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/tsgf_residue_unit.sv
// shared remainder unit: 64-bit value modulo a small prime, four bits a cycle
// depends on tsgf_pkg

module tsgf_residue_unit
   import tsgf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  tsgf_mod_req_type      req,
   input  logic [VALUE_BITS-1:0] value,
   output tsgf_mod_rsp_type      rsp
);

   localparam int STEP_COUNT = VALUE_BITS / DIGIT_BITS;
   localparam int STEP_BITS  = $clog2(STEP_COUNT);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [RES_BITS-1:0]   rem_ff, rem_in;
   logic [RES_BITS-1:0]   mod_ff, mod_in;
   logic [RES_BITS-1:0]   rem_next;

   // restoring reduction over one digit
   always_comb begin
      logic [RES_BITS-1:0] acc;
      logic [RES_BITS:0]   wide;
      acc  = rem_ff;
      wide = '0;
      for (int i = 0; i < DIGIT_BITS; i++) begin
         wide = {acc, val_ff[VALUE_BITS-1-i]};
         if (wide >= {1'b0, mod_ff}) begin
            wide = wide - {1'b0, mod_ff};
         end
         acc = wide[RES_BITS-1:0];
      end
      rem_next = acc;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      mod_in  = mod_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         val_in  = value;
         rem_in  = '0;
         mod_in  = req.modulus;
      end else if (busy_ff) begin
         rem_in  = rem_next;
         val_in  = val_ff << DIGIT_BITS;
         step_in = step_ff + STEP_BITS'(1);
         if (step_ff == STEP_BITS'(STEP_COUNT - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      mod_ff  <= mod_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.residue = rem_ff;

endmodule
